@@ rtl/core/tbpc_pkg.sv @@
package tbpc_pkg;

   localparam int unsigned CountWidth = 16;
   localparam int unsigned EventWidth = 6;
   localparam int unsigned PendWidth  = 4;
   localparam int unsigned CsrIdxWidth = 2;

   localparam logic [CountWidth-1:0] ShortThresholdReset = 16'd100;
   localparam logic [CountWidth-1:0] LongThresholdReset  = 16'd1000;
   localparam logic [CountWidth-1:0] WindowTicksReset    = 16'd100;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_SHORT_THRESHOLD = 2'd0,
      CSR_LONG_THRESHOLD  = 2'd1,
      CSR_WINDOW_TICKS    = 2'd2
   } csr_index_type;

   localparam logic [EventWidth-1:0] EvBothShort = 6'h10;
   localparam logic [EventWidth-1:0] EvBothLong  = 6'h20;
   localparam logic [PendWidth-1:0]  PendBothShort = 4'b0101;
   localparam logic [PendWidth-1:0]  PendBothLong  = 4'b1010;

   typedef struct packed {
      logic key1_level;
      logic key2_level;
   } req_type;

   typedef struct packed {
      logic                  publish;
      logic [EventWidth-1:0] event_bits;
   } rsp_type;

   typedef struct packed {
      logic short_event;
      logic long_event;
      logic count_zero;
   } lane_status_type;

endpackage

@@ rtl/core/tbpc_key_lane.sv @@
module tbpc_key_lane (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 step,
   input  logic                                 level,
   input  logic [tbpc_pkg::CountWidth-1:0]      short_threshold,
   input  logic [tbpc_pkg::CountWidth-1:0]      long_threshold,
   output tbpc_pkg::lane_status_type            status
);
   import tbpc_pkg::*;

   logic                  last_ff, last_in;
   logic                  held_ff, held_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  held_now;
   logic [CountWidth-1:0] count_inc;

   always_comb begin
      held_now  = (level != last_ff) ? level : held_ff;
      count_inc = count_ff + 1'b1;
      last_in   = level;
      held_in   = held_now;
      count_in  = count_ff;
      status    = '0;
      if (held_now) begin
         if (count_inc >= long_threshold) begin
            count_in          = '0;
            held_in           = 1'b0;
            status.long_event = 1'b1;
         end else begin
            count_in = count_inc;
         end
      end else if (count_ff > short_threshold) begin
         count_in           = '0;
         status.short_event = 1'b1;
      end
      status.count_zero = (count_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff  <= 1'b0;
         held_ff  <= 1'b0;
         count_ff <= '0;
      end else if (step) begin
         last_ff  <= last_in;
         held_ff  <= held_in;
         count_ff <= count_in;
      end
   end

endmodule

@@ rtl/core/tbpc_merge.sv @@
module tbpc_merge (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step,
   input  logic [tbpc_pkg::CountWidth-1:0] window_ticks,
   input  tbpc_pkg::lane_status_type       key1_status,
   input  tbpc_pkg::lane_status_type       key2_status,
   output tbpc_pkg::rsp_type               result
);
   import tbpc_pkg::*;

   logic [CountWidth-1:0] window_ff, window_in;
   logic [PendWidth-1:0]  pending_ff, pending_in;
   logic [PendWidth-1:0]  pending_all;
   logic [CountWidth-1:0] window_inc;
   logic [CountWidth-1:0] window_len;
   logic                  expire;

   always_comb begin
      pending_all = pending_ff | {key2_status.long_event, key2_status.short_event,
                                  key1_status.long_event, key1_status.short_event};
      window_len  = (window_ticks == '0) ? CountWidth'(1) : window_ticks;
      window_inc  = window_ff + 1'b1;
      expire      = (window_inc >= window_len);
      window_in   = expire ? '0 : window_inc;
      pending_in  = pending_all;
      result      = '0;
      if (expire && key1_status.count_zero && key2_status.count_zero
          && (pending_all != '0)) begin
         result.publish = 1'b1;
         pending_in     = '0;
         if ((pending_all & PendBothShort) == PendBothShort) begin
            result.event_bits = EvBothShort;
         end else if ((pending_all & PendBothLong) == PendBothLong) begin
            result.event_bits = EvBothLong;
         end else begin
            result.event_bits = {{(EventWidth-PendWidth){1'b0}}, pending_all};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff  <= '0;
         pending_ff <= '0;
      end else if (step) begin
         window_ff  <= window_in;
         pending_ff <= pending_in;
      end
   end

endmodule

@@ rtl/core/two_button_press_classifier_core.sv @@
// Two-key short/long press classifier. Each transfer on the req channel is one tick
// carrying both key levels and yields exactly one transfer on the rsp channel through
// an output register. Throughput is one tick per clock: the two key lanes and the
// window counter update on each accepted tick, so req_stall is raised only while
// that register holds a result that rsp_stall is blocking. The user writes registers
// through csr_we/csr_index/csr_wdata only while idle, which the block itself does not
// enforce; indexes beyond the window register are ignored.
module two_button_press_classifier_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  tbpc_pkg::req_type                req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output tbpc_pkg::rsp_type                rsp_payload,
   input  logic                             csr_we,
   input  logic [tbpc_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [tbpc_pkg::CountWidth-1:0]  csr_wdata
);
   import tbpc_pkg::*;

   logic [CountWidth-1:0] short_threshold_ff;
   logic [CountWidth-1:0] long_threshold_ff;
   logic [CountWidth-1:0] window_ticks_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_payload_ff;
   rsp_type               result;
   lane_status_type       key1_status;
   lane_status_type       key2_status;
   logic                  req_take;

   assign req_stall    = rsp_valid_ff && rsp_stall;
   assign req_take     = req_valid && !req_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_payload  = rsp_payload_ff;
   assign rsp_valid_in = req_take || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         short_threshold_ff <= ShortThresholdReset;
         long_threshold_ff  <= LongThresholdReset;
         window_ticks_ff    <= WindowTicksReset;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SHORT_THRESHOLD: short_threshold_ff <= csr_wdata;
            CSR_LONG_THRESHOLD:  long_threshold_ff  <= csr_wdata;
            CSR_WINDOW_TICKS:    window_ticks_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   tbpc_key_lane u_key1 (
      .clock           (clock),
      .reset           (reset),
      .step            (req_take),
      .level           (req_payload.key1_level),
      .short_threshold (short_threshold_ff),
      .long_threshold  (long_threshold_ff),
      .status          (key1_status)
   );

   tbpc_key_lane u_key2 (
      .clock           (clock),
      .reset           (reset),
      .step            (req_take),
      .level           (req_payload.key2_level),
      .short_threshold (short_threshold_ff),
      .long_threshold  (long_threshold_ff),
      .status          (key2_status)
   );

   tbpc_merge u_merge (
      .clock        (clock),
      .reset        (reset),
      .step         (req_take),
      .window_ticks (window_ticks_ff),
      .key1_status  (key1_status),
      .key2_status  (key2_status),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_take) begin
         rsp_payload_ff <= result;
      end
   end

   a_take_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_valid)
      else $error("accepted tick produced no result");

   a_no_pub_no_events: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.publish |-> rsp_payload.event_bits == '0)
      else $error("event bits set without publish");

   a_both_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.event_bits[5:4] != 2'b00)
      |-> $onehot(rsp_payload.event_bits[5:4]) && rsp_payload.event_bits[3:0] == 4'b0000)
      else $error("combined event mixed with other bits");

   a_full_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> req_stall)
      else $error("input taken while result register blocked");

endmodule

@@ tb/press_event_checker.sv @@
module press_event_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  tbpc_pkg::req_type                req_payload,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  tbpc_pkg::rsp_type                rsp_payload,
   input  logic                             csr_we,
   input  logic [tbpc_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [tbpc_pkg::CountWidth-1:0]  csr_wdata,
   output int                               mismatches,
   output int                               outstanding,
   output int                               ticks_checked,
   output int                               publishes,
   output logic [tbpc_pkg::EventWidth-1:0]  events_seen
);
   timeunit 1ns;
   timeprecision 1ps;
   import tbpc_pkg::*;

   logic [CountWidth-1:0] cfg_short;
   logic [CountWidth-1:0] cfg_long;
   logic [CountWidth-1:0] cfg_window;

   logic [1:0]            last_level;
   logic [1:0]            held;
   logic [CountWidth-1:0] hold_count [2];
   logic [CountWidth-1:0] window_count;
   logic [PendWidth-1:0]  pending;

   rsp_type expected_results [$];

   initial begin
      mismatches    = 0;
      outstanding   = 0;
      ticks_checked = 0;
      publishes     = 0;
      events_seen   = '0;
   end

   // one tick: edges, then both key lanes, then the publish window
   function automatic rsp_type classify_tick(input req_type tick);
      logic [1:0]            lvl;
      logic [CountWidth-1:0] win;
      rsp_type               res;
      lvl = {tick.key2_level, tick.key1_level};
      win = (cfg_window == '0) ? CountWidth'(1) : cfg_window;
      res = '0;
      for (int k = 0; k < 2; k++) begin
         if (lvl[k] != last_level[k]) held[k] = lvl[k];
         last_level[k] = lvl[k];
      end
      for (int k = 0; k < 2; k++) begin
         if (held[k]) begin
            hold_count[k] = hold_count[k] + 1'b1;
            if (hold_count[k] >= cfg_long) begin
               hold_count[k] = '0;
               pending[2*k+1] = 1'b1;
               held[k] = 1'b0;
            end
         end else if (hold_count[k] > cfg_short) begin
            hold_count[k] = '0;
            pending[2*k] = 1'b1;
         end
      end
      window_count = window_count + 1'b1;
      if (window_count >= win) begin
         window_count = '0;
         if (hold_count[0] == '0 && hold_count[1] == '0 && pending != '0) begin
            if ((pending & PendBothShort) == PendBothShort) res.event_bits = EvBothShort;
            else if ((pending & PendBothLong) == PendBothLong) res.event_bits = EvBothLong;
            else res.event_bits = EventWidth'(pending);
            res.publish = 1'b1;
            pending = '0;
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         cfg_short     = ShortThresholdReset;
         cfg_long      = LongThresholdReset;
         cfg_window    = WindowTicksReset;
         last_level    = '0;
         held          = '0;
         hold_count[0] = '0;
         hold_count[1] = '0;
         window_count  = '0;
         pending       = '0;
         expected_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               $error("result transfer with no tick pending: publish=%0b event_bits=%h",
                      rsp_payload.publish, rsp_payload.event_bits);
            end else begin
               want = expected_results.pop_front();
               ticks_checked++;
               if (rsp_payload.publish !== want.publish) begin
                  mismatches++;
                  $error("publish: expected %0b, actual %0b",
                         want.publish, rsp_payload.publish);
               end
               if (rsp_payload.event_bits !== want.event_bits) begin
                  mismatches++;
                  $error("event_bits: expected %h, actual %h",
                         want.event_bits, rsp_payload.event_bits);
               end
               if (rsp_payload.publish === 1'b1) publishes++;
               events_seen |= rsp_payload.event_bits;
            end
         end
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_SHORT_THRESHOLD: cfg_short  = csr_wdata;
               CSR_LONG_THRESHOLD:  cfg_long   = csr_wdata;
               CSR_WINDOW_TICKS:    cfg_window = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) expected_results.push_back(classify_tick(req_payload));
      end
      outstanding = expected_results.size();
   end

endmodule

@@ tb/tb_top.sv @@
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import tbpc_pkg::*;

   localparam int StallLimit = 2000;
   localparam int TickTarget = 550;
   localparam int HoldOffCycles = 60;
   localparam int SettleCycles = 4;
   localparam logic [CsrIdxWidth-1:0] CsrUnusedIndex = 2'd3;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_payload;
   logic                   csr_we = 1'b0;
   logic [CsrIdxWidth-1:0] csr_index = '0;
   logic [CountWidth-1:0]  csr_wdata = '0;

   int                     mismatches;
   int                     outstanding;
   int                     ticks_checked;
   int                     publishes;
   logic [EventWidth-1:0]  events_seen;

   int                     ticks_sent = 0;
   int                     settings_used = 0;
   int                     idle_cycles = 0;
   bit                     quiet_req = 1'b0;
   bit                     quiet_rsp = 1'b0;
   bit                     hold_off_now = 1'b0;
   logic [CountWidth-1:0]  cur_long = LongThresholdReset;

   always #5 clock = ~clock;

   two_button_press_classifier_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   press_event_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .mismatches    (mismatches),
      .outstanding   (outstanding),
      .ticks_checked (ticks_checked),
      .publishes     (publishes),
      .events_seen   (events_seen)
   );

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= StallLimit) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // result side: random stalls per transfer, plus an occasional long hold-off
   initial begin : rsp_side
      int wait_cycles;
      wait (!reset);
      forever begin
         if (hold_off_now) begin
            hold_off_now = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HoldOffCycles) @(posedge clock);
         end
         wait_cycles = quiet_rsp ? 0 : $urandom_range(0, 5);
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   task automatic send_tick(input req_type tick);
      int gap;
      gap = quiet_req ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= tick;
      do @(posedge clock); while (req_stall);
      ticks_sent++;
   endtask

   task automatic hold_keys(input logic k1, input logic k2, input int n);
      req_type tick;
      tick.key1_level = k1;
      tick.key2_level = k2;
      repeat (n) send_tick(tick);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (outstanding == 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic apply_config(input logic [CountWidth-1:0] short_v,
                               input logic [CountWidth-1:0] long_v,
                               input logic [CountWidth-1:0] win_v);
      csr_we    <= 1'b1;
      csr_index <= CSR_SHORT_THRESHOLD;
      csr_wdata <= short_v;
      @(posedge clock);
      csr_index <= CSR_LONG_THRESHOLD;
      csr_wdata <= long_v;
      @(posedge clock);
      csr_index <= CSR_WINDOW_TICKS;
      csr_wdata <= win_v;
      @(posedge clock);
      // unmapped index must be ignored
      csr_index <= CsrUnusedIndex;
      csr_wdata <= CountWidth'($urandom());
      @(posedge clock);
      csr_we <= 1'b0;
      cur_long = long_v;
      settings_used++;
   endtask

   // well-formed presses with random lengths and overlap, some line noise
   task automatic run_presses(input int budget);
      int      start;
      int      which;
      int      len1;
      int      len2;
      int      off;
      int      span;
      int      gap_len;
      int      max_press;
      req_type tick;
      start = ticks_sent;
      max_press = (cur_long > 12) ? 20 : int'(cur_long) + 3;
      while (ticks_sent - start < budget) begin
         if ($urandom_range(0, 9) < 8) begin
            which = $urandom_range(1, 3);
            len1 = $urandom_range(1, max_press);
            len2 = $urandom_range(1, max_press);
            off = $urandom_range(0, 1) ? 0 : $urandom_range(0, 4);
            span = (which[0] ? len1 : 0) > (which[1] ? off + len2 : 0) ?
                   len1 : off + len2;
            for (int t = 0; t < span; t++) begin
               tick.key1_level = which[0] && t < len1;
               tick.key2_level = which[1] && t >= off && t < off + len2;
               send_tick(tick);
            end
            gap_len = $urandom_range(1, 8);
            hold_keys(1'b0, 1'b0, gap_len);
         end else begin
            repeat ($urandom_range(2, 8)) begin
               tick = req_type'(2'($urandom_range(0, 3)));
               send_tick(tick);
            end
         end
      end
   endtask

   initial begin : stimulus
      logic [CountWidth-1:0] short_v;
      logic [CountWidth-1:0] long_v;
      logic [CountWidth-1:0] win_v;
      int                    phase;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero window, key1 short, both short, key2 long, both long, too-brief press blocking publish
      apply_config(16'd1, 16'd4, 16'd0);
      hold_keys(1'b1, 1'b0, 3);
      hold_keys(1'b0, 1'b0, 1);
      hold_keys(1'b1, 1'b1, 3);
      hold_keys(1'b0, 1'b0, 1);
      hold_keys(1'b0, 1'b1, 5);
      hold_keys(1'b0, 1'b0, 1);
      hold_keys(1'b1, 1'b1, 4);
      hold_keys(1'b0, 1'b0, 1);
      hold_keys(1'b1, 1'b0, 1);
      hold_keys(1'b0, 1'b1, 2);
      hold_keys(1'b0, 1'b0, 1);
      settle();
      // zero long threshold, window at max so nothing publishes yet
      apply_config(16'd1, 16'd0, 16'hFFFF);
      hold_keys(1'b1, 1'b1, 2);
      hold_keys(1'b0, 1'b0, 1);
      settle();
      // window lowered below the running window count
      apply_config(16'd0, 16'hFFFF, 16'd2);
      hold_keys(1'b0, 1'b0, 3);
      settle();

      phase = 0;
      while (ticks_sent < TickTarget) begin
         case ($urandom_range(0, 9))
            0: short_v = '0;
            1: short_v = 16'hFFFF;
            default: short_v = CountWidth'($urandom_range(0, 6));
         endcase
         case ($urandom_range(0, 9))
            0: long_v = '0;
            1: long_v = 16'hFFFF;
            default: long_v = CountWidth'($urandom_range(1, 12));
         endcase
         case ($urandom_range(0, 9))
            0: win_v = '0;
            1: win_v = 16'hFFFF;
            2: win_v = 16'd1;
            default: win_v = CountWidth'($urandom_range(2, 20));
         endcase
         apply_config(short_v, long_v, win_v);
         quiet_req = ($urandom_range(0, 3) == 0);
         quiet_rsp = ($urandom_range(0, 3) == 0);
         if (phase == 2 || $urandom_range(0, 5) == 0) begin
            quiet_req = 1'b1;
            hold_off_now = 1'b1;
         end
         run_presses($urandom_range(40, 70));
         settle();
         phase++;
      end

      repeat (SettleCycles) @(posedge clock);
      $display("Sent %0d key ticks under %0d register settings; %0d results checked.",
               ticks_sent, settings_used, ticks_checked);
      $display("%0d publishes, event bits seen %06b.", publishes, events_seen);
      if (mismatches == 0 && outstanding == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/tbpc_pkg.sv
rtl/core/tbpc_key_lane.sv
rtl/core/tbpc_merge.sv
rtl/core/two_button_press_classifier_core.sv
tb/press_event_checker.sv
tb/tb_top.sv
